/* sv/lmh_pkg.sv */
// Package for the link multiboot master handshake: codes, command words,
// phase encoding and the structs passed between lanes and the controller.
// No dependencies.
`default_nettype none

package lmh_pkg;

  localparam int unsigned NumClients = 3;

  localparam logic [6:0] HEADER_WORDS = 7'd96;
  localparam logic [3:0] PROBE_TRIES  = 4'd15;
  localparam logic [3:0] PROBE_ROUNDS = 4'd15;

  // command words and reply patterns
  localparam logic [15:0] CMD_PROBE   = 16'h6200;
  localparam logic [15:0] CMD_CONFIRM = 16'h6100;
  localparam logic [15:0] CMD_PAL     = 16'h6300;
  localparam logic [15:0] CMD_HSHAKE  = 16'h6400;
  localparam logic [15:0] PROBE_MASK  = 16'hfff0;
  localparam logic [7:0]  RPL_PROBE   = 8'h72;
  localparam logic [7:0]  RPL_PAL     = 8'h73;
  localparam logic [7:0]  PAL_REQ     = 8'h81;
  localparam logic [7:0]  HS_SEED     = 8'h11;

  // configuration register indexes
  localparam logic [1:0] CFG_WANTED  = 2'd0;
  localparam logic [1:0] CFG_PALETTE = 2'd1;

  localparam logic [3:0] WANTED_RST  = 4'd14;
  localparam logic [7:0] PALETTE_RST = 8'd129;

  // result actions
  localparam logic [1:0] ACT_SEND  = 2'd0;
  localparam logic [1:0] ACT_WAIT  = 2'd1;
  localparam logic [1:0] ACT_DONE  = 2'd2;
  localparam logic [1:0] ACT_ERROR = 2'd3;

  // event modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_XFER  = 2'd1;
  localparam logic [1:0] MODE_DELAY = 2'd2;

  // reply check kinds, index into lane_res_t.bad
  localparam int unsigned ChkProbe  = 0;
  localparam int unsigned ChkHeader = 1;
  localparam int unsigned ChkAck    = 2;
  localparam int unsigned ChkPal    = 3;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_PALETTE   = 4'd1,
    ERR_NOT_MSTR  = 4'd2,
    ERR_TIMEOUT   = 4'd3,
    ERR_STAGE_HDR = 4'd4,
    ERR_BAD_HDR   = 4'd5,
    ERR_ACK_HDR   = 4'd6,
    ERR_STAGE_PAL = 4'd7,
    ERR_ACK_PAL   = 4'd8
  } err_e;

  typedef enum logic [8:0] {
    PH_IDLE       = 9'b000000001,
    PH_PROBE      = 9'b000000010,
    PH_PROBE_WAIT = 9'b000000100,
    PH_CONFIRM    = 9'b000001000,
    PH_HEADER     = 9'b000010000,
    PH_ACK_HEADER = 9'b000100000,
    PH_STAGE_PAL  = 9'b001000000,
    PH_PAL_LOOP   = 9'b010000000,
    PH_FINAL      = 9'b100000000
  } phase_e;

  // per-client findings for one response halfword
  typedef struct packed {
    logic [3:0] probe_bits;  // client bits seen in a probe reply
    logic [3:0] bad;         // failed check, one bit per check kind
    logic       pal_hit;     // palette reply from a connected client
    logic [7:0] pal_byte;
  } lane_res_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] send_word;
    err_e        error_code;
    logic [3:0]  client_flags;
    logic [6:0]  next_header_index;
    logic [7:0]  handshake_byte;
    logic [7:0]  client1_byte;
    logic [7:0]  client2_byte;
    logic [7:0]  client3_byte;
  } result_t;

endpackage

`default_nettype wire

/* sv/lmh_lane.sv */
// One client lane: checks a response halfword against every reply pattern.
// Depends on lmh_pkg.
`default_nettype none

module lmh_lane import lmh_pkg::*; (
  input  wire logic [15:0] resp_i,
  input  wire logic [3:0]  client_bit_i,   // one-hot bit of this client
  input  wire logic        connected_i,
  input  wire logic [7:0]  hdr_count_i,    // expected header countdown
  output lane_res_t        res_o
);

  logic ok_probe, ok_hdr, ok_ack, ok_pal;

  always_comb begin
    ok_probe = (resp_i == {RPL_PROBE, 4'h0, client_bit_i});
    ok_hdr   = (resp_i == {hdr_count_i, 4'h0, client_bit_i});
    ok_ack   = (resp_i == {12'h000, client_bit_i});
    ok_pal   = (resp_i[15:8] == RPL_PAL);

    res_o.probe_bits = ((resp_i & PROBE_MASK) == {RPL_PROBE, 8'h00})
                       ? {resp_i[3:1], 1'b0} : 4'h0;
    res_o.bad[ChkProbe]  = connected_i && !ok_probe;
    res_o.bad[ChkHeader] = connected_i && !ok_hdr;
    res_o.bad[ChkAck]    = connected_i && !ok_ack;
    res_o.bad[ChkPal]    = connected_i && !ok_pal;
    res_o.pal_hit  = connected_i && ok_pal;
    res_o.pal_byte = resp_i[7:0];
  end

endmodule

`default_nettype wire

/* sv/link_multiboot_master_handshake.sv */
// Link multiboot master handshake: phase controller, three client lanes, result skid.
// Results are registered in the out register, or in the spare skid slot while the output stalls.
// One event accepted per cycle while the skid slot is empty; a full skid slot holds off events.
// Reset: phase idle, masks and counters cleared, reply bytes 0xff, registers at defaults.
// Depends on lmh_pkg and lmh_lane.
`default_nettype none

module link_multiboot_master_handshake import lmh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // event requests
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic        so_line_high_i,
  input  wire logic [15:0] client1_response_i,
  input  wire logic [15:0] client2_response_i,
  input  wire logic [15:0] client3_response_i,
  input  wire logic [15:0] header_word_i,
  // result requests
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       action_o,
  output logic [15:0]      send_word_o,
  output logic [3:0]       error_code_o,
  output logic [3:0]       client_flags_o,
  output logic [6:0]       next_header_index_o,
  output logic [7:0]       handshake_byte_o,
  output logic [7:0]       client1_byte_o,
  output logic [7:0]       client2_byte_o,
  output logic [7:0]       client3_byte_o
);

  // configuration
  logic [3:0] wanted_q;
  logic [7:0] palette_q;

  // handshake state
  phase_e     phase_q, phase_d;
  logic [3:0] conn_q, conn_d;
  logic [3:0] try_q, try_d;
  logic [3:0] round_q, round_d;
  logic [6:0] hpos_q, hpos_d;
  logic [3:0] pend_q, pend_d;
  logic [7:0] reply_q [NumClients];
  logic [7:0] reply_d [NumClients];

  // result skid: out register plus one spare slot
  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q, res_valid;
  logic    in_acc;

  // lanes
  logic [15:0] resp [NumClients];
  lane_res_t   lane [NumClients];
  logic [7:0]  hdr_count;

  assign resp[0] = client1_response_i;
  assign resp[1] = client2_response_i;
  assign resp[2] = client3_response_i;

  // countdown the clients echo for the header word just sent
  assign hdr_count = 8'({1'b0, HEADER_WORDS}) + 8'd1 - {1'b0, hpos_q};

  for (genvar g = 0; g < NumClients; g++) begin : g_lane
    lmh_lane u_lane (
      .resp_i       (resp[g]),
      .client_bit_i (4'(1 << (g + 1))),
      .connected_i  (conn_q[g + 1]),
      .hdr_count_i  (hdr_count),
      .res_o        (lane[g])
    );
  end

  // merge stage: lane findings into client masks
  logic [3:0] probe_bits;
  logic [3:0] bad_probe, bad_hdr, bad_ack, bad_pal;
  logic [3:0] conn_probe, try_inc, round_inc;
  logic [7:0] hs_byte;

  always_comb begin
    probe_bits = lane[0].probe_bits | lane[1].probe_bits | lane[2].probe_bits;
    bad_probe  = {lane[2].bad[ChkProbe],  lane[1].bad[ChkProbe],  lane[0].bad[ChkProbe],  1'b0};
    bad_hdr    = {lane[2].bad[ChkHeader], lane[1].bad[ChkHeader], lane[0].bad[ChkHeader], 1'b0};
    bad_ack    = {lane[2].bad[ChkAck],    lane[1].bad[ChkAck],    lane[0].bad[ChkAck],    1'b0};
    bad_pal    = {lane[2].bad[ChkPal],    lane[1].bad[ChkPal],    lane[0].bad[ChkPal],    1'b0};
    conn_probe = conn_q | probe_bits;
    try_inc    = try_q + 4'd1;
    round_inc  = round_q + 4'd1;
  end

  assign in_ready_o  = !skid_valid_q;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;

  // event decode and next state
  always_comb begin
    phase_d   = phase_q;
    conn_d    = conn_q;
    try_d     = try_q;
    round_d   = round_q;
    hpos_d    = hpos_q;
    pend_d    = pend_q;
    reply_d   = reply_q;
    res       = '0;
    res.error_code = ERR_NONE;
    res_valid = 1'b0;
    hs_byte   = 8'h00;

    case (mode_i)
      MODE_START: begin
        res_valid = 1'b1;
        conn_d  = 4'h0;
        try_d   = 4'h0;
        round_d = 4'h0;
        hpos_d  = 7'd0;
        pend_d  = 4'h0;
        for (int i = 0; i < NumClients; i++) reply_d[i] = 8'hff;
        if ((palette_q & PAL_REQ) != PAL_REQ) begin
          phase_d = PH_IDLE;
          res.action = ACT_ERROR;
          res.error_code = ERR_PALETTE;
        end else if (so_line_high_i) begin
          phase_d = PH_IDLE;
          res.action = ACT_ERROR;
          res.error_code = ERR_NOT_MSTR;
        end else begin
          phase_d = PH_PROBE;
          res.action = ACT_SEND;
          res.send_word = CMD_PROBE;
        end
      end

      MODE_DELAY: begin
        if (phase_q == PH_PROBE_WAIT) begin
          res_valid = 1'b1;
          try_d   = 4'h0;
          phase_d = PH_PROBE;
          res.action = ACT_SEND;
          res.send_word = CMD_PROBE;
        end
      end

      MODE_XFER: begin
        case (phase_q)
          PH_PROBE: begin
            res_valid = 1'b1;
            conn_d = conn_probe;
            if (try_inc < PROBE_TRIES) begin
              try_d = try_inc;
              res.action = ACT_SEND;
              res.send_word = CMD_PROBE;
            end else begin
              try_d = 4'h0;
              if (conn_probe == 4'h0 && round_inc < PROBE_ROUNDS) begin
                // nobody answered this round: ask for a pause and retry
                round_d = round_inc;
                phase_d = PH_PROBE_WAIT;
                res.action = ACT_WAIT;
              end else begin
                if (conn_probe == 4'h0) round_d = round_inc;
                if ((conn_probe & wanted_q) == 4'h0) begin
                  phase_d = PH_IDLE;
                  res.action = ACT_ERROR;
                  res.error_code = ERR_TIMEOUT;
                  res.client_flags = conn_probe;
                end else begin
                  conn_d = conn_probe & wanted_q;
                  phase_d = PH_CONFIRM;
                  res.action = ACT_SEND;
                  res.send_word = CMD_CONFIRM | {12'h000, conn_probe & wanted_q};
                end
              end
            end
          end

          PH_CONFIRM: begin
            res_valid = 1'b1;
            if (bad_probe != 4'h0) begin
              phase_d = PH_IDLE;
              res.action = ACT_ERROR;
              res.error_code = ERR_STAGE_HDR;
              res.client_flags = bad_probe;
            end else begin
              hpos_d  = 7'd1;
              phase_d = PH_HEADER;
              res.action = ACT_SEND;
              res.send_word = header_word_i;
            end
          end

          PH_HEADER: begin
            res_valid = 1'b1;
            if (bad_hdr != 4'h0) begin
              phase_d = PH_IDLE;
              res.action = ACT_ERROR;
              res.error_code = ERR_BAD_HDR;
              res.client_flags = bad_hdr;
            end else if (hpos_q < HEADER_WORDS) begin
              hpos_d = hpos_q + 7'd1;
              res.action = ACT_SEND;
              res.send_word = header_word_i;
            end else begin
              phase_d = PH_ACK_HEADER;
              res.action = ACT_SEND;
              res.send_word = CMD_PROBE;
            end
          end

          PH_ACK_HEADER: begin
            res_valid = 1'b1;
            if (bad_ack != 4'h0) begin
              phase_d = PH_IDLE;
              res.action = ACT_ERROR;
              res.error_code = ERR_ACK_HDR;
              res.client_flags = bad_ack;
            end else begin
              phase_d = PH_STAGE_PAL;
              res.action = ACT_SEND;
              res.send_word = CMD_PROBE | {12'h000, conn_q};
            end
          end

          PH_STAGE_PAL: begin
            res_valid = 1'b1;
            if (bad_probe != 4'h0) begin
              phase_d = PH_IDLE;
              res.action = ACT_ERROR;
              res.error_code = ERR_STAGE_PAL;
              res.client_flags = bad_probe;
            end else begin
              pend_d = conn_q;
              for (int i = 0; i < NumClients; i++) reply_d[i] = 8'hff;
              phase_d = PH_PAL_LOOP;
              res.action = ACT_SEND;
              res.send_word = CMD_PAL | {8'h00, palette_q};
            end
          end

          PH_PAL_LOOP: begin
            res_valid = 1'b1;
            for (int i = 0; i < NumClients; i++) begin
              if (lane[i].pal_hit) begin
                reply_d[i] = lane[i].pal_byte;
                pend_d[i + 1] = 1'b0;
              end
            end
            hs_byte = HS_SEED + reply_d[0] + reply_d[1] + reply_d[2];
            res.action = ACT_SEND;
            if (pend_d != 4'h0) begin
              res.send_word = CMD_PAL | {8'h00, palette_q};
            end else begin
              phase_d = PH_FINAL;
              res.send_word = CMD_HSHAKE | {8'h00, hs_byte};
              res.handshake_byte = hs_byte;
            end
          end

          PH_FINAL: begin
            res_valid = 1'b1;
            phase_d = PH_IDLE;
            hs_byte = HS_SEED + reply_q[0] + reply_q[1] + reply_q[2];
            if (bad_pal != 4'h0) begin
              res.action = ACT_ERROR;
              res.error_code = ERR_ACK_PAL;
              res.client_flags = bad_pal;
            end else begin
              res.action = ACT_DONE;
              res.client_flags = conn_q;
              res.handshake_byte = hs_byte;
            end
          end

          default: begin
            // idle or waiting: a finished transfer means nothing here
          end
        endcase
      end

      default: begin
        // unused mode: dropped without a result
      end
    endcase

    res.next_header_index = hpos_d;
    res.client1_byte = reply_d[0];
    res.client2_byte = reply_d[1];
    res.client3_byte = reply_d[2];
  end

  // control and configuration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q  <= WANTED_RST;
      palette_q <= PALETTE_RST;
      phase_q   <= PH_IDLE;
      conn_q    <= 4'h0;
      try_q     <= 4'h0;
      round_q   <= 4'h0;
      hpos_q    <= 7'd0;
      pend_q    <= 4'h0;
      for (int i = 0; i < NumClients; i++) reply_q[i] <= 8'hff;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_WANTED:  wanted_q  <= cfg_data_i[3:0];
          CFG_PALETTE: palette_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        phase_q <= phase_d;
        conn_q  <= conn_d;
        try_q   <= try_d;
        round_q <= round_d;
        hpos_q  <= hpos_d;
        pend_q  <= pend_d;
        reply_q <= reply_d;
      end
    end
  end

  // result skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_ready_i) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_acc && res_valid;
        end
      end else if (in_acc && res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc && res_valid) begin
        out_q <= res;
      end
    end else if (in_acc && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign action_o            = out_q.action;
  assign send_word_o         = out_q.send_word;
  assign error_code_o        = out_q.error_code;
  assign client_flags_o      = out_q.client_flags;
  assign next_header_index_o = out_q.next_header_index;
  assign handshake_byte_o    = out_q.handshake_byte;
  assign client1_byte_o      = out_q.client1_byte;
  assign client2_byte_o      = out_q.client2_byte;
  assign client3_byte_o      = out_q.client3_byte;

endmodule

`default_nettype wire
